// ----- hdl/bpfa_pkg.sv -----
`timescale 1ns / 1ps

package bpfa_pkg;

    // Geometry of the managed memory
    localparam int MAX_PAGES    = 4096;
    localparam int PAGE_SHIFT   = 12;

    // Field widths
    localparam int ADDR_W       = 52;
    localparam int CNT_W        = 13;
    localparam int PAGE_ADDR_W  = 24;
    localparam int STATUS_W     = 3;

    // Bitmap organization: one word per memory entry
    localparam int WORD_W       = 64;
    localparam int BIT_IDX_W    = $clog2(WORD_W);
    localparam int PAGE_IDX_W   = $clog2(MAX_PAGES);
    localparam int WORDS        = MAX_PAGES / WORD_W;
    localparam int WORD_IDX_W   = $clog2(WORDS);

    // Stream payload widths
    localparam int IN_DATA_W    = ((ADDR_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STATUS_W + PAGE_ADDR_W + 2 * CNT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_OK           = 3'd0;
    localparam t_status ST_FULL         = 3'd1;
    localparam t_status ST_MISALIGNED   = 3'd2;
    localparam t_status ST_ALREADY_FREE = 3'd3;
    localparam t_status ST_BEYOND       = 3'd4;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

endpackage

// ----- hdl/bitmap_page_frame_allocator.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Beat contents
// -------   ---  -------------------------------------------------------------
// s_axis    in   tuser: req_type; tdata: addr (bits 51:0), zero pad to 56
// m_axis    out  tdata: status, page_addr, used_pages, free_pages, zero pad
// cfg       in   i_cfg_wr_en / i_cfg_wr_data: page_count, written on any enabled edge
//
// Allocate: accepted in S_IDLE; S_SCAN examines 64-page bitmap words in order (1 to 64,
//   next word read while one is examined); S_DONE hands off when m_axis can take it.
// Free: S_FREE then S_DONE; zero-count allocate: S_DONE only. One request at a time.
// s_axis_tready is high whenever the engine is idle, even with a result still held.
// Synchronous active-low reset clears the word valid bits, the used count, the state
//   and the output valid; page_count returns to 4096. A stalled m_axis holds the result.

module bitmap_page_frame_allocator
    import bpfa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [51:0] addr, [55:52] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] req_type
    input  logic                  s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [2:0] status, [26:3] page_addr, [39:27] used_pages, [52:40] free_pages, [55:53] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,

    input  logic                  i_cfg_wr_en,
    input  logic [CNT_W-1:0]      i_cfg_wr_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FREE = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam int PA_FULL_W = PAGE_IDX_W + PAGE_SHIFT;

    // Bitmap RAM: one word per entry, plus a valid bit per word so reset is instant
    logic [WORD_W-1:0]     mem [WORDS];
    logic [WORDS-1:0]      r_word_vld;
    logic [WORD_W-1:0]     r_rd_data;
    logic                  r_rd_vld;

    logic [1:0]            r_state, n_state;
    logic [WORD_IDX_W-1:0] r_word, n_word;
    logic [ADDR_W-1:0]     r_addr;
    logic [CNT_W-1:0]      r_used, n_used;
    logic [CNT_W-1:0]      r_page_count;
    t_status               r_res_status, n_res_status;
    logic [PAGE_ADDR_W-1:0] r_res_paddr, n_res_paddr;

    logic                  r_m_valid;
    t_status               r_m_status;
    logic [PAGE_ADDR_W-1:0] r_m_paddr;
    logic [CNT_W-1:0]      r_m_used;
    logic [CNT_W-1:0]      r_m_free;

    logic                  w_accept;
    logic                  w_load;
    logic                  w_rd_en;
    logic [WORD_IDX_W-1:0] w_raddr;
    logic                  w_we;
    logic [WORD_IDX_W-1:0] w_waddr;
    logic [WORD_W-1:0]     w_wdata;

    logic [CNT_W-1:0]      w_cnt;
    logic [CNT_W-1:0]      w_cnt_m1;
    logic [WORD_IDX_W-1:0] w_last_word;
    logic [BIT_IDX_W-1:0]  w_last_bit;
    logic [WORD_W-1:0]     w_word;
    logic [WORD_W-1:0]     w_mask;
    logic [WORD_W-1:0]     w_free_bits;
    logic                  w_hit;
    logic [BIT_IDX_W-1:0]  w_hit_bit;
    logic [PA_FULL_W-1:0]  w_hit_paddr;

    logic [PAGE_IDX_W-1:0] w_free_idx;
    logic                  w_misaligned;
    logic                  w_beyond;
    logic                  w_bit_used;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Effective page count saturates at the bitmap size
    assign w_cnt       = (r_page_count > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES)
                                                            : r_page_count;
    assign w_cnt_m1    = w_cnt - CNT_W'(1);
    assign w_last_word = w_cnt_m1[PAGE_IDX_W-1:BIT_IDX_W];
    assign w_last_bit  = w_cnt_m1[BIT_IDX_W-1:0];

    // A word never written since reset reads as all free
    assign w_word = r_rd_vld ? r_rd_data : '0;

    // In the last word, only pages below the count are candidates
    assign w_mask = (r_word == w_last_word)
                  ? ({WORD_W{1'b1}} >> (BIT_IDX_W'(WORD_W - 1) - w_last_bit))
                  : {WORD_W{1'b1}};
    assign w_free_bits = ~w_word & w_mask;
    assign w_hit       = |w_free_bits;

    // Lowest free bit of the current word
    always_comb begin
        w_hit_bit = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (w_free_bits[i]) begin
                w_hit_bit = BIT_IDX_W'(i);
            end
        end
    end

    assign w_hit_paddr = PA_FULL_W'({r_word, w_hit_bit}) << PAGE_SHIFT;

    // Free checks on the latched address
    assign w_free_idx   = r_addr[PAGE_SHIFT+PAGE_IDX_W-1:PAGE_SHIFT];
    assign w_misaligned = |r_addr[PAGE_SHIFT-1:0];
    assign w_beyond     = (|r_addr[ADDR_W-1:PAGE_SHIFT+PAGE_IDX_W])
                       || ({1'b0, w_free_idx} >= w_cnt);
    assign w_bit_used   = w_word[w_free_idx[BIT_IDX_W-1:0]];

    always_comb begin
        n_state      = r_state;
        n_word       = r_word;
        n_used       = r_used;
        n_res_status = r_res_status;
        n_res_paddr  = r_res_paddr;
        w_rd_en      = 1'b0;
        w_raddr      = r_word + WORD_IDX_W'(1);
        w_we         = 1'b0;
        w_waddr      = r_word;
        w_wdata      = w_word;
        w_load       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_word      = '0;
                    n_res_paddr = '0;
                    if (s_axis_tuser == REQ_FREE) begin
                        // Fetch the word holding the page; checks follow next cycle
                        w_rd_en = 1'b1;
                        w_raddr = s_axis_tdata[PAGE_SHIFT+PAGE_IDX_W-1:PAGE_SHIFT+BIT_IDX_W];
                        n_state = S_FREE;
                    end else if (w_cnt == '0) begin
                        n_res_status = ST_FULL;
                        n_state      = S_DONE;
                    end else begin
                        w_rd_en = 1'b1;
                        w_raddr = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Prefetch the next word while examining this one
                w_rd_en = 1'b1;
                if (w_hit) begin
                    w_we         = 1'b1;
                    w_wdata      = w_word | (WORD_W'(1) << w_hit_bit);
                    n_used       = r_used + CNT_W'(1);
                    n_res_status = ST_OK;
                    n_res_paddr  = PAGE_ADDR_W'(w_hit_paddr);
                    n_state      = S_DONE;
                end else if (r_word == w_last_word) begin
                    n_res_status = ST_FULL;
                    n_state      = S_DONE;
                end else begin
                    n_word = r_word + WORD_IDX_W'(1);
                end
            end
            S_FREE: begin
                w_waddr = w_free_idx[PAGE_IDX_W-1:BIT_IDX_W];
                n_state = S_DONE;
                priority if (w_misaligned) begin
                    n_res_status = ST_MISALIGNED;
                end else if (w_beyond) begin
                    n_res_status = ST_BEYOND;
                end else if (!w_bit_used) begin
                    n_res_status = ST_ALREADY_FREE;
                end else begin
                    w_we         = 1'b1;
                    w_wdata      = w_word & ~(WORD_W'(1) << w_free_idx[BIT_IDX_W-1:0]);
                    n_used       = (r_used != '0) ? r_used - CNT_W'(1) : r_used;
                    n_res_status = ST_OK;
                end
            end
            S_DONE: begin
                // Hand off once the output register is empty or draining
                if (!r_m_valid || m_axis_tready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Bitmap RAM, read data registered
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_rd_en) begin
            r_rd_data <= mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_vld <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            if (w_we) begin
                r_word_vld[w_waddr] <= 1'b1;
            end
            if (w_rd_en) begin
                r_rd_vld <= r_word_vld[w_raddr];
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_used       <= '0;
            r_page_count <= CNT_W'(MAX_PAGES);
            r_m_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            if (i_cfg_wr_en) begin
                r_page_count <= i_cfg_wr_data;
            end
            if (w_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_word       <= n_word;
        r_res_status <= n_res_status;
        r_res_paddr  <= n_res_paddr;
        if (w_accept) begin
            r_addr <= s_axis_tdata[ADDR_W-1:0];
        end
        if (w_load) begin
            r_m_status <= r_res_status;
            r_m_paddr  <= r_res_paddr;
            r_m_used   <= r_used;
            r_m_free   <= (w_cnt > r_used) ? w_cnt - r_used : '0;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}},
                            r_m_free, r_m_used, r_m_paddr, r_m_status};

endmodule

// ----- hdl/bpfa_checker.sv -----
`timescale 1ns / 1ps

module bpfa_checker
    import bpfa_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_status                w_status;
    logic [PAGE_ADDR_W-1:0] w_paddr;
    logic [CNT_W-1:0]       w_used;
    logic [CNT_W-1:0]       w_free;

    assign w_status = m_axis_tdata[STATUS_W-1:0];
    assign w_paddr  = m_axis_tdata[STATUS_W+PAGE_ADDR_W-1:STATUS_W];
    assign w_used   = m_axis_tdata[STATUS_W+PAGE_ADDR_W+CNT_W-1:STATUS_W+PAGE_ADDR_W];
    assign w_free   = m_axis_tdata[OUT_FIELDS_W-1:STATUS_W+PAGE_ADDR_W+CNT_W];

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Only a successful allocate carries an address
    a_paddr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_status != ST_OK) |-> (w_paddr == '0))
        else $error("page address set on a failed request");

    // Full means no page left below the count
    a_full_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_status == ST_FULL) |-> (w_free == '0))
        else $error("full reported with free pages left");

    // Counts stay within the bitmap and addresses stay page aligned
    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_used <= CNT_W'(MAX_PAGES)) && (w_free <= CNT_W'(MAX_PAGES))
                          && (w_paddr[PAGE_SHIFT-1:0] == '0))
        else $error("count out of range or page address misaligned");

endmodule

bind bitmap_page_frame_allocator bpfa_checker u_bpfa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
